// ===== rtl/smsc_pkg.sv =====
// ----------------------------------------------------------------------------
// smsc_pkg: shared types and constants of the SQL marker scanner
// Lane count, position width, character codes and transaction structs.
// ----------------------------------------------------------------------------
package smsc_pkg;

  localparam int LANES                = 8;
  localparam int POSITION_BITS        = 24;
  localparam int BYTE_BITS            = 8;
  localparam int CHUNK_BITS           = 64;
  localparam int COUNT_BITS           = 4;
  localparam int MARKER_POSITION_BITS = 24;

  localparam int LANE_IDX_BITS = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int LANE_CNT_BITS = $clog2(LANES + 1);

  localparam logic [BYTE_BITS-1:0] CH_DQUOTE    = 8'h22;
  localparam logic [BYTE_BITS-1:0] CH_SQUOTE    = 8'h27;
  localparam logic [BYTE_BITS-1:0] CH_BACKTICK  = 8'h60;
  localparam logic [BYTE_BITS-1:0] CH_SLASH     = 8'h2F;
  localparam logic [BYTE_BITS-1:0] CH_HASH      = 8'h23;
  localparam logic [BYTE_BITS-1:0] CH_MINUS     = 8'h2D;
  localparam logic [BYTE_BITS-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [BYTE_BITS-1:0] CH_DOLLAR    = 8'h24;
  localparam logic [BYTE_BITS-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [BYTE_BITS-1:0] CH_DIGIT_LO  = 8'h30;
  localparam logic [BYTE_BITS-1:0] CH_DIGIT_HI  = 8'h39;
  localparam logic [BYTE_BITS-1:0] CH_LOWER_LO  = 8'h61;
  localparam logic [BYTE_BITS-1:0] CH_LOWER_HI  = 8'h7A;
  localparam logic [BYTE_BITS-1:0] CH_UPPER_LO  = 8'h41;
  localparam logic [BYTE_BITS-1:0] CH_UPPER_HI  = 8'h5A;

  typedef struct packed {
    logic [CHUNK_BITS-1:0] chunk_bytes;
    logic [COUNT_BITS-1:0] byte_count;
    logic                  new_text;
  } chunk_t;

  typedef struct packed {
    logic [MARKER_POSITION_BITS-1:0] marker_position;
    logic                            last_marker;
    logic                            position_overflow;
  } marker_t;

  typedef struct packed {
    logic marker;
    logic digit;
    logic word;
  } lane_class_t;

  typedef struct packed {
    logic [LANES-1:0]         mask;
    logic [POSITION_BITS-1:0] base;
    logic                     overflowed;
  } work_t;

endpackage

// ===== rtl/smsc_lane.sv =====
// ----------------------------------------------------------------------------
// smsc_lane: byte classifier for one lane
// Flags quote, comment and escape characters, digits and word characters.
// ----------------------------------------------------------------------------
module smsc_lane (
  input  logic [smsc_pkg::BYTE_BITS-1:0] text_byte,
  output smsc_pkg::lane_class_t          lane_class
);

  logic is_letter;

  assign is_letter = ((text_byte >= smsc_pkg::CH_LOWER_LO) && (text_byte <= smsc_pkg::CH_LOWER_HI))
                  || ((text_byte >= smsc_pkg::CH_UPPER_LO) && (text_byte <= smsc_pkg::CH_UPPER_HI));

  assign lane_class.marker = (text_byte == smsc_pkg::CH_DQUOTE)
                          || (text_byte == smsc_pkg::CH_SQUOTE)
                          || (text_byte == smsc_pkg::CH_BACKTICK)
                          || (text_byte == smsc_pkg::CH_SLASH)
                          || (text_byte == smsc_pkg::CH_HASH)
                          || (text_byte == smsc_pkg::CH_MINUS)
                          || (text_byte == smsc_pkg::CH_BACKSLASH);

  assign lane_class.digit = (text_byte >= smsc_pkg::CH_DIGIT_LO)
                         && (text_byte <= smsc_pkg::CH_DIGIT_HI);

  assign lane_class.word = is_letter || lane_class.digit
                        || (text_byte == smsc_pkg::CH_UNDERSCORE)
                        || (text_byte == smsc_pkg::CH_DOLLAR);

endmodule

// ===== rtl/smsc_drain.sv =====
// ----------------------------------------------------------------------------
// smsc_drain: marker merge and output stage
// Holds one chunk's lane mask and emits its markers lowest lane first.
// ----------------------------------------------------------------------------
module smsc_drain (
  input  logic                clk,
  input  logic                rst,
  input  logic                work_valid,
  input  smsc_pkg::work_t     work,
  output logic                work_ready,
  output logic                marker_valid,
  input  logic                marker_stall,
  output smsc_pkg::marker_t   marker
);

  logic                                  stage_valid;
  logic [smsc_pkg::LANES-1:0]            stage_mask;
  logic [smsc_pkg::POSITION_BITS-1:0]    stage_base;
  logic                                  stage_ovf;
  logic [smsc_pkg::LANES-1:0]            rest;
  logic [smsc_pkg::LANE_IDX_BITS-1:0]    pick_idx;
  logic [smsc_pkg::POSITION_BITS:0]      full;
  logic                                  out_free;
  logic                                  load_out;
  logic                                  stage_done;
  smsc_pkg::marker_t                     marker_next;

  assign rest = stage_mask & (stage_mask - 1'b1);

  always_comb begin
    pick_idx = '0;
    for (int i = smsc_pkg::LANES - 1; i >= 0; i--) begin
      if (stage_mask[i]) begin
        pick_idx = smsc_pkg::LANE_IDX_BITS'(i);
      end
    end
  end

  assign full = {1'b0, stage_base} + (smsc_pkg::POSITION_BITS + 1)'(pick_idx);

  assign out_free   = ~marker_valid | ~marker_stall;
  assign load_out   = stage_valid & out_free;
  assign stage_done = load_out & (rest == '0);
  assign work_ready = ~stage_valid | stage_done;

  always_comb begin
    marker_next.marker_position =
      smsc_pkg::MARKER_POSITION_BITS'(full[smsc_pkg::POSITION_BITS-1:0]);
    marker_next.last_marker       = (rest == '0);
    marker_next.position_overflow = stage_ovf | full[smsc_pkg::POSITION_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      marker_valid <= 1'b0;
    end else begin
      if (work_valid && work_ready) begin
        stage_valid <= 1'b1;
      end else if (stage_done) begin
        stage_valid <= 1'b0;
      end
      if (load_out) begin
        marker_valid <= 1'b1;
      end else if (!marker_stall) begin
        marker_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      marker <= marker_next;
    end
    if (work_valid && work_ready) begin
      stage_mask <= work.mask;
      stage_base <= work.base;
      stage_ovf  <= work.overflowed;
    end else if (load_out) begin
      stage_mask <= rest;
    end
  end

  a_stage_nonempty: assert property (@(posedge clk) disable iff (rst)
    stage_valid |-> (stage_mask != '0))
    else $error("held chunk has no markers left");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    marker_valid && !marker_stall && !marker.last_marker |=> marker_valid)
    else $error("gap after a marker that was not the last of its chunk");

  a_rest_held: assert property (@(posedge clk) disable iff (rst)
    marker_valid && !marker.last_marker |-> stage_valid)
    else $error("remaining markers of a chunk lost");

  a_load: assert property (@(posedge clk) disable iff (rst)
    work_valid && work_ready |=> stage_valid)
    else $error("accepted chunk not held");

endmodule

// ===== rtl/sql_marker_scanner.sv =====
// ----------------------------------------------------------------------------
// sql_marker_scanner: marks positions of interest in SQL text
// Eight classifier lanes scan a chunk per transaction; a drain stage emits
// one marker position per cycle in ascending order while marker_stall is low.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                   | payload
//  ---------+-----+-----------------------------+---------------------------
//  chunk    | in  | chunk_valid / chunk_stall   | chunk_t  (bytes, count, new_text)
//  marker   | out | marker_valid / marker_stall | marker_t (position, last, overflow)
//
//  A chunk with no markers bypasses the drain; one with markers holds the drain
//  stage until all have left, one per cycle while marker_stall is low. The next
//  chunk is taken in the cycle the last marker of the held one moves to the
//  output register. Markers pass the stage register, then the output register.
//  Reset clears position, overflow and the word flag (set) and empties the drain.
//  marker_stall holds the output register and, once the drain is full, chunk_stall.
// ----------------------------------------------------------------------------
module sql_marker_scanner (
  input  logic               clk,
  input  logic               rst,
  input  logic               chunk_valid,
  output logic               chunk_stall,
  input  smsc_pkg::chunk_t   chunk,
  output logic               marker_valid,
  input  logic               marker_stall,
  output smsc_pkg::marker_t  marker
);

  logic [smsc_pkg::POSITION_BITS-1:0]  text_position;
  logic                                previous_was_word_char;
  logic                                overflowed;

  logic                                accept;
  logic                                work_ready;
  logic [smsc_pkg::LANE_CNT_BITS-1:0]  lane_count;
  logic [smsc_pkg::LANE_CNT_BITS-1:0]  last_lane;
  logic [smsc_pkg::POSITION_BITS-1:0]  pos_start;
  logic                                ovf_start;
  logic                                prev_start;
  logic [smsc_pkg::POSITION_BITS:0]    pos_sum;
  logic [smsc_pkg::LANES-1:0]          word_vec;
  logic [smsc_pkg::LANES-1:0]          mask;
  logic                                word_next;
  smsc_pkg::lane_class_t               lane_class [smsc_pkg::LANES];
  smsc_pkg::work_t                     work;

  assign accept      = chunk_valid & ~chunk_stall;
  assign chunk_stall = ~work_ready;

  assign lane_count = (chunk.byte_count > smsc_pkg::COUNT_BITS'(smsc_pkg::LANES))
                    ? smsc_pkg::LANE_CNT_BITS'(smsc_pkg::LANES)
                    : chunk.byte_count[smsc_pkg::LANE_CNT_BITS-1:0];
  assign last_lane  = lane_count - 1'b1;

  assign pos_start  = chunk.new_text ? '0   : text_position;
  assign ovf_start  = chunk.new_text ? 1'b0 : overflowed;
  assign prev_start = chunk.new_text ? 1'b1 : previous_was_word_char;

  for (genvar i = 0; i < smsc_pkg::LANES; i++) begin : g_lane
    localparam logic [smsc_pkg::LANE_CNT_BITS-1:0] IDX = smsc_pkg::LANE_CNT_BITS'(i);
    logic prev_word;

    smsc_lane u_lane (
      .text_byte  (chunk.chunk_bytes[i*smsc_pkg::BYTE_BITS +: smsc_pkg::BYTE_BITS]),
      .lane_class (lane_class[i])
    );

    if (i == 0) begin : g_first
      assign prev_word = prev_start;
    end else begin : g_next
      assign prev_word = lane_class[i-1].word;
    end

    assign word_vec[i] = lane_class[i].word;
    assign mask[i] = (IDX < lane_count)
                   & (lane_class[i].marker | (lane_class[i].digit & ~prev_word));
  end

  assign word_next = (lane_count == '0) ? prev_start
                   : word_vec[last_lane[smsc_pkg::LANE_IDX_BITS-1:0]];

  assign pos_sum = {1'b0, pos_start} + (smsc_pkg::POSITION_BITS + 1)'(lane_count);

  always_comb begin
    work.mask       = mask;
    work.base       = pos_start;
    work.overflowed = ovf_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_position          <= '0;
      previous_was_word_char <= 1'b1;
      overflowed             <= 1'b0;
    end else if (accept) begin
      text_position          <= pos_sum[smsc_pkg::POSITION_BITS-1:0];
      previous_was_word_char <= word_next;
      overflowed             <= ovf_start | pos_sum[smsc_pkg::POSITION_BITS];
    end
  end

  smsc_drain u_drain (
    .clk          (clk),
    .rst          (rst),
    .work_valid   (accept & (mask != '0)),
    .work         (work),
    .work_ready   (work_ready),
    .marker_valid (marker_valid),
    .marker_stall (marker_stall),
    .marker       (marker)
  );

endmodule

// ===== test/sql_marker_scanner_tb.sv =====
// ----------------------------------------------------------------------------
// sql_marker_scanner_tb: self-checking bench for the SQL marker scanner
// A table of hand-picked chunks covers the character classes, digit-run rules
// and count edge cases. Random SQL-like text follows, with random gaps on the
// chunk side and random stalls on the marker side. Every marker is compared
// field by field with its row's typed values or a behavioural scanner model.
// ----------------------------------------------------------------------------
module sql_marker_scanner_tb;

  localparam int RANDOM_CHUNKS = 346;
  localparam int MAX_COUNT     = (1 << smsc_pkg::COUNT_BITS) - 1;

  typedef struct packed {
    logic [smsc_pkg::CHUNK_BITS-1:0]           text;
    logic [smsc_pkg::COUNT_BITS-1:0]           count;
    logic                                      restart;
    logic                                      typed;
    logic                                      has_marker;
    logic [smsc_pkg::MARKER_POSITION_BITS-1:0] typed_position;
    logic                                      typed_last;
    logic                                      typed_overflow;
  } scan_row_t;

  // text, count, restart, typed, has_marker, position, last, overflow
  scan_row_t directed_rows [19] = '{
    '{64'h0000_0000_0000_2737, 4'd2,  1'b0, 1'b1, 1'b1, 24'h000001, 1'b1, 1'b0},
    '{64'h205C_2D23_2F60_2722, 4'd8,  1'b0, 1'b0, 1'b0, 24'h000000, 1'b0, 1'b0},
    '{64'h345F_3361_3231_2035, 4'd8,  1'b0, 1'b0, 1'b0, 24'h000000, 1'b0, 1'b0},
    '{64'h395B_393A_3940_3924, 4'd8,  1'b0, 1'b0, 1'b0, 24'h000000, 1'b0, 1'b0},
    '{64'h2222_2222_2222_2222, 4'd0,  1'b0, 1'b1, 1'b0, 24'h000000, 1'b0, 1'b0},
    '{64'h2D2D_2D2D_2D2D_2D2D, 4'd0,  1'b1, 1'b1, 1'b0, 24'h000000, 1'b0, 1'b0},
    '{64'h0000_0000_0000_002D, 4'd1,  1'b0, 1'b1, 1'b1, 24'h000000, 1'b1, 1'b0},
    '{64'h2323_2323_2323_2323, 4'd15, 1'b1, 1'b0, 1'b0, 24'h000000, 1'b0, 1'b0},
    '{64'hFF80_B0A2_A7AF_DCE0, 4'd8,  1'b1, 1'b1, 1'b0, 24'h000000, 1'b0, 1'b0},
    '{64'h0000_0000_0000_0031, 4'd1,  1'b0, 1'b1, 1'b1, 24'h000008, 1'b1, 1'b0},
    '{64'h0000_0000_0000_0000, 4'd8,  1'b1, 1'b1, 1'b0, 24'h000000, 1'b0, 1'b0},
    '{64'h0000_0000_0000_0030, 4'd1,  1'b0, 1'b1, 1'b1, 24'h000008, 1'b1, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b0, 1'b1, 1'b0, 24'h000000, 1'b0, 1'b0},
    '{64'h5A67_662D_6427_6261, 4'd8,  1'b1, 1'b0, 1'b0, 24'h000000, 1'b0, 1'b0},
    '{64'h2727_2727_272D_2039, 4'd3,  1'b0, 1'b0, 1'b0, 24'h000000, 1'b0, 1'b0},
    '{64'h327B_3160_393A_302F, 4'd8,  1'b0, 1'b0, 1'b0, 24'h000000, 1'b0, 1'b0},
    '{64'h0000_0000_0000_0035, 4'd1,  1'b1, 1'b1, 1'b0, 24'h000000, 1'b0, 1'b0},
    '{64'h317A_3161_315A_3141, 4'd8,  1'b0, 1'b0, 1'b0, 24'h000000, 1'b0, 1'b0},
    '{64'h317B_3160_315B_3140, 4'd8,  1'b0, 1'b0, 1'b0, 24'h000000, 1'b0, 1'b0}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              chunk_valid;
  logic              chunk_stall;
  smsc_pkg::chunk_t  chunk;
  logic              marker_valid;
  logic              marker_stall = 1'b0;
  smsc_pkg::marker_t marker;

  logic [smsc_pkg::POSITION_BITS-1:0] scan_position   = '0;
  logic                               scan_word_prev  = 1'b1;
  logic                               scan_overflowed = 1'b0;

  smsc_pkg::marker_t chunk_markers[$];
  smsc_pkg::marker_t expected_markers[$];
  int                mismatches      = 0;
  bit                sender_steady   = 1'b0;
  int unsigned       steady_cycles   = 0;
  int unsigned       stall_cycles    = 0;

  sql_marker_scanner DUT (
    .clk          (clk),
    .rst          (rst),
    .chunk_valid  (chunk_valid),
    .chunk_stall  (chunk_stall),
    .chunk        (chunk),
    .marker_valid (marker_valid),
    .marker_stall (marker_stall),
    .marker       (marker)
  );

  always #1 clk = ~clk;

  function automatic bit is_marker_char(logic [smsc_pkg::BYTE_BITS-1:0] ch);
    return ch == smsc_pkg::CH_DQUOTE || ch == smsc_pkg::CH_SQUOTE ||
           ch == smsc_pkg::CH_BACKTICK || ch == smsc_pkg::CH_SLASH ||
           ch == smsc_pkg::CH_HASH || ch == smsc_pkg::CH_MINUS ||
           ch == smsc_pkg::CH_BACKSLASH;
  endfunction

  function automatic bit is_word_letter(logic [smsc_pkg::BYTE_BITS-1:0] ch);
    return (ch >= smsc_pkg::CH_LOWER_LO && ch <= smsc_pkg::CH_LOWER_HI) ||
           (ch >= smsc_pkg::CH_UPPER_LO && ch <= smsc_pkg::CH_UPPER_HI) ||
           ch == smsc_pkg::CH_UNDERSCORE || ch == smsc_pkg::CH_DOLLAR;
  endfunction

  // Scan one chunk into chunk_markers and advance the text state.
  function automatic void scan_chunk(smsc_pkg::chunk_t c);
    int                                 lanes_used;
    logic [smsc_pkg::POSITION_BITS:0]   full;
    logic [smsc_pkg::BYTE_BITS-1:0]     ch;
    bit                                 digit;
    smsc_pkg::marker_t                  m;
    chunk_markers.delete();
    if (c.new_text) begin
      scan_position   = '0;
      scan_word_prev  = 1'b1;
      scan_overflowed = 1'b0;
    end
    lanes_used = (c.byte_count > smsc_pkg::LANES) ? smsc_pkg::LANES : int'(c.byte_count);
    for (int i = 0; i < lanes_used; i++) begin
      ch    = c.chunk_bytes[smsc_pkg::BYTE_BITS*i +: smsc_pkg::BYTE_BITS];
      digit = ch >= smsc_pkg::CH_DIGIT_LO && ch <= smsc_pkg::CH_DIGIT_HI;
      full  = {1'b0, scan_position} + (smsc_pkg::POSITION_BITS + 1)'(i);
      if (is_marker_char(ch) || (digit && !scan_word_prev)) begin
        m.marker_position   =
          smsc_pkg::MARKER_POSITION_BITS'(full[smsc_pkg::POSITION_BITS-1:0]);
        m.last_marker       = 1'b0;
        m.position_overflow = scan_overflowed || full[smsc_pkg::POSITION_BITS];
        chunk_markers = {chunk_markers, m};
      end
      scan_word_prev = digit || is_word_letter(ch);
    end
    if (chunk_markers.size() != 0)
      chunk_markers[chunk_markers.size() - 1].last_marker = 1'b1;
    full = {1'b0, scan_position} + (smsc_pkg::POSITION_BITS + 1)'(lanes_used);
    if (full[smsc_pkg::POSITION_BITS])
      scan_overflowed = 1'b1;
    scan_position = full[smsc_pkg::POSITION_BITS-1:0];
  endfunction

  function automatic logic [smsc_pkg::BYTE_BITS-1:0] text_byte();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)
      return smsc_pkg::BYTE_BITS'(($urandom_range(0, 1) ? smsc_pkg::CH_LOWER_LO
                                                        : smsc_pkg::CH_UPPER_LO) +
                                  $urandom_range(0, 25));
    if (pick < 50)
      return smsc_pkg::BYTE_BITS'(smsc_pkg::CH_DIGIT_LO + $urandom_range(0, 9));
    if (pick < 62) begin
      case ($urandom_range(0, 5))
        0: return 8'h20;
        1: return 8'h28;
        2: return 8'h29;
        3: return 8'h2C;
        4: return 8'h3D;
        default: return 8'h0A;
      endcase
    end
    if (pick < 78) begin
      case ($urandom_range(0, 6))
        0: return smsc_pkg::CH_DQUOTE;
        1: return smsc_pkg::CH_SQUOTE;
        2: return smsc_pkg::CH_BACKTICK;
        3: return smsc_pkg::CH_SLASH;
        4: return smsc_pkg::CH_HASH;
        5: return smsc_pkg::CH_MINUS;
        default: return smsc_pkg::CH_BACKSLASH;
      endcase
    end
    if (pick < 84)
      return $urandom_range(0, 1) ? smsc_pkg::CH_UNDERSCORE : smsc_pkg::CH_DOLLAR;
    if (pick < 90)
      return smsc_pkg::BYTE_BITS'($urandom_range(128, 255));
    return smsc_pkg::BYTE_BITS'($urandom_range(0, 255));
  endfunction

  function automatic scan_row_t random_row();
    scan_row_t   r;
    int unsigned pick;
    r = '0;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      r.count = smsc_pkg::COUNT_BITS'(smsc_pkg::LANES);
    else if (pick < 92)
      r.count = smsc_pkg::COUNT_BITS'($urandom_range(1, smsc_pkg::LANES - 1));
    else if (pick < 96)
      r.count = '0;
    else
      r.count = smsc_pkg::COUNT_BITS'($urandom_range(smsc_pkg::LANES + 1, MAX_COUNT));
    r.restart = ($urandom_range(0, 19) == 0);
    if ($urandom_range(0, 9) == 0)
      r.text = {$urandom, $urandom};
    else
      for (int i = 0; i < smsc_pkg::LANES; i++)
        r.text[smsc_pkg::BYTE_BITS*i +: smsc_pkg::BYTE_BITS] = text_byte();
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      return 0;
    if (pick < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  // Offer one chunk, hold it until taken, then queue the markers it causes.
  task automatic send_row(input scan_row_t r, input bit paced);
    smsc_pkg::chunk_t  c;
    smsc_pkg::marker_t typed_m;
    int unsigned       gap;
    c.chunk_bytes = r.text;
    c.byte_count  = r.count;
    c.new_text    = r.restart;
    gap = (paced && !sender_steady) ? pick_gap() : 0;
    if (gap > 0) begin
      chunk_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chunk_valid <= 1'b1;
    chunk       <= c;
    @(posedge clk);
    while (chunk_stall) @(posedge clk);
    scan_chunk(c);
    if (!r.typed) begin
      expected_markers = {expected_markers, chunk_markers};
    end else if (r.has_marker) begin
      typed_m.marker_position   = r.typed_position;
      typed_m.last_marker       = r.typed_last;
      typed_m.position_overflow = r.typed_overflow;
      expected_markers = {expected_markers, typed_m};
    end
  endtask

  always @(posedge clk) begin : receiver_pace
    int unsigned pick;
    if (steady_cycles > 0) begin
      steady_cycles--;
      marker_stall <= 1'b0;
    end else if (stall_cycles > 0) begin
      stall_cycles--;
      marker_stall <= 1'b1;
    end else begin
      pick = $urandom_range(0, 999);
      if (pick < 5)
        steady_cycles = $urandom_range(50, 200);
      else if (pick < 250)
        stall_cycles = $urandom_range(1, 3);
      else if (pick < 280)
        stall_cycles = $urandom_range(10, 40);
      marker_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_markers
    smsc_pkg::marker_t want;
    if (!rst && marker_valid && !marker_stall) begin
      if (expected_markers.size() == 0) begin
        $error("marker_position: expected none, got %0h", marker.marker_position);
        mismatches++;
      end else begin
        want = expected_markers.pop_front();
        compare_field("marker_position", 32'(want.marker_position),
                      32'(marker.marker_position));
        compare_field("last_marker", 32'(want.last_marker), 32'(marker.last_marker));
        compare_field("position_overflow", 32'(want.position_overflow),
                      32'(marker.position_overflow));
      end
    end
  end

  initial begin
    rst          = 1'b1;
    chunk_valid  = 1'b0;
    chunk        = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_row(directed_rows[i], 1'b1);

    for (int n = 0; n < RANDOM_CHUNKS; n++) begin
      if (n % 32 == 0)
        sender_steady = ($urandom_range(0, 3) == 0);
      send_row(random_row(), 1'b1);
    end
    chunk_valid <= 1'b0;

    while (expected_markers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/smsc_pkg.sv
rtl/smsc_lane.sv
rtl/smsc_drain.sv
rtl/sql_marker_scanner.sv
test/sql_marker_scanner_tb.sv
